// ----- design/ptip_pkg.sv -----
// Shared types, constants and a saturation helper for the puck intercept planner.
`default_nettype none
package ptip_pkg;

	localparam int POS_W = 24;
	localparam int VEL_W = 16;
	localparam int VST_W = VEL_W + 1;
	localparam int BND_W = 23;
	localparam int STP_W = 10;
	localparam int BNC_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;
	localparam int SUM_W = POS_W + 1;

	localparam logic [BNC_W-1:0] BOUNCE_LIMIT = 3'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TABLE_BOUND_X = 3'd0,
		REG_TABLE_BOUND_Y = 3'd1,
		REG_IMPACT_LINE_X = 3'd2,
		REG_SHOOT_WINDOW  = 3'd3,
		REG_BLOCK_BACKOFF = 3'd4,
		REG_HOME_X        = 3'd5,
		REG_HOME_Y        = 3'd6,
		REG_HORIZON       = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_HOME  = 2'd0,
		ACT_BLOCK = 2'd1,
		ACT_SHOOT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [VST_W-1:0] vx;
		logic signed [VST_W-1:0] vy;
	} walk_t;

	typedef struct packed {
		logic flip_x;
		logic flip_y;
		logic crossed;
	} step_flags_t;

	// clamp a 25-bit signed value to the 24-bit position range
	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v[SUM_W-1] != v[SUM_W-2])
			r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/ptip_step.sv -----
// One tick of the puck walk: wall reflection, position update, line test.
`default_nettype none
module ptip_step (
	input  wire ptip_pkg::walk_t                    cur,
	input  wire logic [ptip_pkg::BND_W-1:0]         bound_x,
	input  wire logic [ptip_pkg::BND_W-1:0]         bound_y,
	input  wire logic signed [ptip_pkg::POS_W-1:0]  line_x,
	output ptip_pkg::walk_t                         nxt,
	output ptip_pkg::step_flags_t                   flags
);
	import ptip_pkg::*;

	logic signed [SUM_W-1:0] x_ext, y_ext, bx_ext, by_ext;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [VST_W-1:0] vx_n, vy_n;

	always_comb begin
		x_ext  = {cur.x[POS_W-1], cur.x};
		y_ext  = {cur.y[POS_W-1], cur.y};
		bx_ext = {2'b00, bound_x};
		by_ext = {2'b00, bound_y};

		// |p| > bound, tested on both sides of zero
		flags.flip_x = (x_ext > bx_ext) || (x_ext < -bx_ext);
		flags.flip_y = (y_ext > by_ext) || (y_ext < -by_ext);

		vx_n = flags.flip_x ? -cur.vx : cur.vx;
		vy_n = flags.flip_y ? -cur.vy : cur.vy;

		sum_x = x_ext + {{(SUM_W-VST_W){vx_n[VST_W-1]}}, vx_n};
		sum_y = y_ext + {{(SUM_W-VST_W){vy_n[VST_W-1]}}, vy_n};

		nxt.x  = sat_pos(sum_x);
		nxt.y  = sat_pos(sum_y);
		nxt.vx = vx_n;
		nxt.vy = vy_n;

		flags.crossed = nxt.x < line_x;
	end

endmodule
`default_nettype wire

// ----- design/puck_trajectory_intercept_planner.sv -----
// Sequence: a request is loaded and walked for at most min(horizon, MAX_STEPS) ticks, one tick
// per cycle; the walk stops early on a line crossing or a third bounce, and the result
// then waits in S_FINISH until the output register is free.
// Throughput: one request per walk; the step unit is reused for every tick and in_stall
// stays high from acceptance until the result enters the output register.
// Reset: arst_n clears the sequencer and output valid, and loads the register defaults.
`default_nettype none
module puck_trajectory_intercept_planner #(
	parameter int MAX_STEPS = 1024
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire [ptip_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire [ptip_pkg::CFG_DAT_W-1:0]           cfg_data,
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire logic signed [ptip_pkg::POS_W-1:0]  puck_x,
	input  wire logic signed [ptip_pkg::POS_W-1:0]  puck_y,
	input  wire logic signed [ptip_pkg::VEL_W-1:0]  puck_vx,
	input  wire logic signed [ptip_pkg::VEL_W-1:0]  puck_vy,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output ptip_pkg::action_t                       action,
	output logic signed [ptip_pkg::POS_W-1:0]       target_x,
	output logic signed [ptip_pkg::POS_W-1:0]       target_y,
	output logic [ptip_pkg::STP_W-1:0]              impact_step,
	output logic [ptip_pkg::BNC_W-1:0]              bounce_count
);
	import ptip_pkg::*;

	localparam int MAX_W = $clog2(MAX_STEPS + 1);
	localparam int CNT_W = (MAX_W > STP_W) ? MAX_W : STP_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

	// configuration registers
	logic [BND_W-1:0]        bound_x_q, bound_y_q, backoff_q;
	logic signed [POS_W-1:0] line_x_q, home_x_q, home_y_q;
	logic [STP_W-1:0]        window_q, horizon_q;

	state_t state_q, state_n;

	walk_t            walk_q, walk_n;
	step_flags_t      flags;
	logic [BNC_W-1:0] bounces_q, bounces_n;
	logic [CNT_W-1:0] cnt_q, limit_q, step_i, limit_in;
	logic [CNT_W-1:0] hit_q;

	logic load, step_en, result_load;

	logic signed [SUM_W-1:0] block_diff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_x_q <= 23'd1400000;
			bound_y_q <= 23'd650000;
			line_x_q  <= -24'sd250000;
			window_q  <= 10'd100;
			backoff_q <= 23'd50000;
			home_x_q  <= -24'sd450000;
			home_y_q  <= 24'sd0;
			horizon_q <= 10'd500;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TABLE_BOUND_X: bound_x_q <= cfg_data[BND_W-1:0];
				REG_TABLE_BOUND_Y: bound_y_q <= cfg_data[BND_W-1:0];
				REG_IMPACT_LINE_X: line_x_q  <= cfg_data[POS_W-1:0];
				REG_SHOOT_WINDOW:  window_q  <= cfg_data[STP_W-1:0];
				REG_BLOCK_BACKOFF: backoff_q <= cfg_data[BND_W-1:0];
				REG_HOME_X:        home_x_q  <= cfg_data[POS_W-1:0];
				REG_HOME_Y:        home_y_q  <= cfg_data[POS_W-1:0];
				REG_HORIZON:       horizon_q <= cfg_data[STP_W-1:0];
				default: ;
			endcase
		end
	end

	ptip_step u_step (
		.cur     (walk_q),
		.bound_x (bound_x_q),
		.bound_y (bound_y_q),
		.line_x  (line_x_q),
		.nxt     (walk_n),
		.flags   (flags)
	);

	assign bounces_n = bounces_q + BNC_W'(flags.flip_x) + BNC_W'(flags.flip_y);
	assign step_i    = cnt_q + CNT_W'(1);
	assign limit_in  = (CNT_W'(horizon_q) > MAX_CNT) ? MAX_CNT : CNT_W'(horizon_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n     = state_q;
		in_stall    = 1'b1;
		load        = 1'b0;
		step_en     = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					load    = 1'b1;
					state_n = (limit_in == '0) ? S_FINISH : S_WALK;
				end
			end
			S_WALK: begin
				step_en = 1'b1;
				if (flags.crossed || (bounces_n > BOUNCE_LIMIT) || (step_i == limit_q))
					state_n = S_FINISH;
			end
			S_FINISH: begin
				// wait for the output register to free up
				if (!out_valid || !out_stall) begin
					result_load = 1'b1;
					state_n     = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			walk_q.x  <= puck_x;
			walk_q.y  <= puck_y;
			walk_q.vx <= {puck_vx[VEL_W-1], puck_vx};
			walk_q.vy <= {puck_vy[VEL_W-1], puck_vy};
			bounces_q <= '0;
			cnt_q     <= '0;
			hit_q     <= '0;
			limit_q   <= limit_in;
		end else if (step_en) begin
			walk_q    <= walk_n;
			bounces_q <= bounces_n;
			cnt_q     <= step_i;
			if (flags.crossed)
				hit_q <= step_i;
		end
	end

	assign block_diff = {walk_q.x[POS_W-1], walk_q.x} - {2'b00, backoff_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (result_load)
			out_valid <= 1'b1;
		else if (out_valid && !out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			impact_step  <= hit_q[STP_W-1:0];
			bounce_count <= bounces_q;
			if (hit_q == '0) begin
				action   <= ACT_HOME;
				target_x <= home_x_q;
				target_y <= home_y_q;
			end else if (hit_q < CNT_W'(window_q)) begin
				action   <= ACT_SHOOT;
				target_x <= '0;
				target_y <= '0;
			end else begin
				action   <= ACT_BLOCK;
				target_x <= sat_pos(block_diff);
				target_y <= walk_q.y;
			end
		end
	end

endmodule
`default_nettype wire
